/* rtl/core/egbp_pkg.sv */
// ----------------------------------------------------------------------------
// egbp_pkg
// Shared types and codes for the Exp-Golomb bit packer.
// ----------------------------------------------------------------------------
package egbp_pkg;

    localparam logic [1:0] CMD_RAW    = 2'd0;
    localparam logic [1:0] CMD_UE     = 2'd1;
    localparam logic [1:0] CMD_SE     = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ARG   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int RAW_MAX_BITS = 32;
    localparam int FIELD_W      = 64;
    localparam int PEND_W       = 7;
    localparam int QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [5:0]  raw_len;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [1:0]  status;
        logic [31:0] total_bits;
        logic        last;
    } out_item_t;

    // One classified command: the bits to append, left-aligned, and their count.
    typedef struct packed {
        logic                 finish;
        logic [FIELD_W-1:0]   field_l;
        logic [5:0]           len;
        logic [1:0]           status;
    } work_t;

endpackage

/* rtl/core/exp_golomb_bit_packer.sv */
// ----------------------------------------------------------------------------
// exp_golomb_bit_packer
// MSB-first bitstream packer for raw fields and Exp-Golomb codes.
// ----------------------------------------------------------------------------
// The block takes one command per cycle unless full is high, and returns one
// result beat per completed byte, or a single beat with byte_valid low when no
// byte completes; the last beat of each command has last set. A command that
// completes k bytes (up to eight) holds the byte-wide output register for one
// beat per byte. Results pass through the decode stage and the four-entry queue,
// from which the bit assembler loads the output register. The queue absorbs
// output stalls.
module exp_golomb_bit_packer
    import egbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic  f_valid;
    logic  f_ready;
    work_t f_work;
    logic  q_valid;
    logic  q_take;
    work_t q_work;

    egbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .work_valid (f_valid),
        .work_ready (f_ready),
        .work       (f_work)
    );

    egbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_work),
        .rd_valid (q_valid),
        .rd_take  (q_take),
        .rd_data  (q_work)
    );

    egbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (q_valid),
        .work_take  (q_take),
        .work       (q_work),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

/* rtl/core/egbp_front.sv */
// ----------------------------------------------------------------------------
// egbp_front
// Decodes commands, checks arguments and builds the left-aligned code word.
// ----------------------------------------------------------------------------
module egbp_front
    import egbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     work_valid,
    input  logic     work_ready,
    output work_t    work
);

    logic        s1_valid_reg;
    logic        s1_is_code_reg;
    logic        s1_finish_reg;
    logic [31:0] s1_word_reg;
    logic [5:0]  s1_cnt_reg;
    logic [1:0]  s1_status_reg;

    logic        s1_is_code_next;
    logic [31:0] s1_word_next;
    logic [5:0]  s1_cnt_next;
    logic [1:0]  s1_status_next;

    logic        take;
    logic [32:0] ue_sum;
    logic [31:0] mag;
    logic        raw_bad;
    logic [4:0]  lead;
    logic [5:0]  len;
    logic [6:0]  shamt;

    function automatic logic [4:0] top_one(input logic [31:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (w[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    assign take = push && !full;
    assign full = s1_valid_reg && !work_ready;

    assign ue_sum  = {1'b0, item.value} + 33'd1;
    assign mag     = ~item.value + 32'd1;
    assign raw_bad = (item.raw_len > 6'(RAW_MAX_BITS))
                  || ((item.raw_len < 6'(RAW_MAX_BITS))
                      && ((item.value >> item.raw_len) != 32'd0));

    always_comb
    begin
        s1_is_code_next = 1'b0;
        s1_word_next    = '0;
        s1_cnt_next     = '0;
        s1_status_next  = ST_OK;
        case (item.cmd)
            CMD_RAW:
            begin
                if (raw_bad) begin
                    s1_status_next = ST_ARG;
                end else begin
                    s1_word_next = item.value;
                    s1_cnt_next  = item.raw_len;
                end
            end
            CMD_UE:
            begin
                if (ue_sum[32]) begin
                    s1_status_next = ST_RANGE;
                end else begin
                    s1_is_code_next = 1'b1;
                    s1_word_next    = ue_sum[31:0];
                end
            end
            CMD_SE:
            begin
                // The code word is the mapped value plus one: 2v for positive v,
                // and -2v + 1 otherwise.
                if (item.value == 32'h8000_0000) begin
                    s1_status_next = ST_RANGE;
                end else if (!item.value[31] && item.value != 32'd0) begin
                    s1_is_code_next = 1'b1;
                    s1_word_next    = {item.value[30:0], 1'b0};
                end else begin
                    s1_is_code_next = 1'b1;
                    s1_word_next    = {mag[30:0], 1'b1};
                end
            end
            default:
            begin
                s1_status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (take) begin
            s1_valid_reg <= 1'b1;
        end else if (work_ready) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            s1_is_code_reg <= s1_is_code_next;
            s1_finish_reg  <= (item.cmd == CMD_FINISH);
            s1_word_reg    <= s1_word_next;
            s1_cnt_reg     <= s1_cnt_next;
            s1_status_reg  <= s1_status_next;
        end
    end

    // An Exp-Golomb code of c is c itself in 2*floor(log2 c) + 1 bits.
    assign lead  = top_one(s1_word_reg);
    assign len   = s1_is_code_reg ? {lead, 1'b1} : s1_cnt_reg;
    assign shamt = 7'(FIELD_W) - {1'b0, len};

    assign work_valid     = s1_valid_reg;
    assign work.finish    = s1_finish_reg;
    assign work.field_l   = {32'd0, s1_word_reg} << shamt;
    assign work.len       = len;
    assign work.status    = s1_status_reg;

endmodule

/* rtl/core/egbp_queue.sv */
// ----------------------------------------------------------------------------
// egbp_queue
// Small first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module egbp_queue
    import egbp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  work_t wr_data,
    output logic  rd_valid,
    input  logic  rd_take,
    output work_t rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    work_t            slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_take && rd_valid;
    assign rd_data  = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/egbp_back.sv */
// ----------------------------------------------------------------------------
// egbp_back
// Appends command bits to the pending bits and sends out completed bytes.
// ----------------------------------------------------------------------------
module egbp_back
    import egbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      work_valid,
    output logic      work_take,
    input  work_t     work,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    localparam int ACC_W = PEND_W + FIELD_W;

    // Pending bits are kept left-aligned; bits past the count are zero.
    logic [PEND_W-1:0] pend_reg;
    logic [2:0]        pc_reg;
    logic [31:0]       total_reg;
    logic [55:0]       sh_reg;
    logic [2:0]        rem_reg;
    logic [1:0]        stat_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;

    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  acc_rest;
    logic [6:0]        nbits;
    logic [3:0]        nbytes;
    logic [32:0]       sum;
    logic [31:0]       total_next;
    logic [PEND_W-1:0] pend_next;
    logic [2:0]        pc_next;
    logic              out_free;
    logic              cont;

    assign out_free  = !out_valid_reg || pop;
    assign cont      = (rem_reg != 3'd0);
    assign work_take = out_free && !cont && work_valid;

    assign acc      = {pend_reg, {FIELD_W{1'b0}}} | ({work.field_l, {PEND_W{1'b0}}} >> pc_reg);
    assign nbits    = 7'(pc_reg) + 7'(work.len);
    assign acc_rest = acc << {nbytes, 3'b000};
    assign sum      = {1'b0, total_reg} + 33'(work.len);

    always_comb
    begin
        if (work.finish) begin
            nbytes     = (pc_reg != 3'd0) ? 4'd1 : 4'd0;
            pend_next  = '0;
            pc_next    = '0;
            total_next = total_reg;
        end else begin
            nbytes     = nbits[6:3];
            pend_next  = acc_rest[ACC_W-1 -: PEND_W];
            pc_next    = nbits[2:0];
            total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg      <= '0;
            pc_reg        <= '0;
            total_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_free && cont) begin
                rem_reg       <= rem_reg - 3'd1;
                out_valid_reg <= 1'b1;
            end else if (work_take) begin
                pend_reg      <= pend_next;
                pc_reg        <= pc_next;
                total_reg     <= total_next;
                rem_reg       <= (nbytes != 4'd0) ? 3'(nbytes - 4'd1) : 3'd0;
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && cont) begin
            sh_reg             <= {sh_reg[47:0], 8'd0};
            out_reg.out_byte   <= sh_reg[55:48];
            out_reg.byte_valid <= 1'b1;
            out_reg.status     <= stat_reg;
            out_reg.total_bits <= total_reg;
            out_reg.last       <= (rem_reg == 3'd1);
        end else if (work_take) begin
            sh_reg             <= acc[ACC_W-9 -: 56];
            stat_reg           <= work.status;
            out_reg.out_byte   <= (nbytes != 4'd0) ? acc[ACC_W-1 -: 8] : 8'd0;
            out_reg.byte_valid <= (nbytes != 4'd0);
            out_reg.status     <= work.status;
            out_reg.total_bits <= total_next;
            out_reg.last       <= (nbytes <= 4'd1);
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule
